// ===== sv/hcb_pkg.sv =====
package hcb_pkg;

   localparam int SYMBOLS     = 32;
   localparam int FREQ_BITS   = 16;
   localparam int ADDR_LIMIT  = 32;
   localparam int SPAN        = (SYMBOLS < ADDR_LIMIT) ? SYMBOLS : ADDR_LIMIT;
   localparam int SLOT_BITS   = 5;
   localparam int CNT_BITS    = SLOT_BITS + 1;
   localparam int WEIGHT_BITS = FREQ_BITS + SLOT_BITS;
   localparam int CODE_BITS   = 31;
   localparam int LEN_BITS    = 5;
   localparam int ENTRY_BITS  = CODE_BITS + LEN_BITS;
   localparam longint unsigned FREQ_MASK = (64'd1 << FREQ_BITS) - 64'd1;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_BUILD  = 2'd1,
      CMD_ENCODE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ABSENT    = 2'd1,
      ST_NOT_BUILT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PACK_RD, S_PACK_WR, S_A_RD, S_A_CMP, S_B_RD, S_B_CMP,
      S_M_LO, S_M_HI, S_R_RD, S_R_CODE, S_R_HI, S_R_LO,
      S_ENC_MAP, S_ENC_CODE, S_OUT
   } state_type;

endpackage

// ===== sv/hcb_ram.sv =====
module hcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/huffman_code_builder.sv =====
// Huffman code builder.
// Request channel (req_*): one command per request. tdata carries cmd, symbol and
// frequency. Load stores a frequency (zero marks the symbol absent) and drops the
// built codes; build derives a code per present symbol; encode returns one code.
// Response channel (rsp_*): exactly one response per request, in order: status,
// code bits (first bit at code_length-1) and code length.
// Build time grows with the number of present symbols. The memories have one write
// port and one registered read port: every scan step of a merge reads one weight
// entry, and each step issues a read and then uses it.
// One request is worked on at a time; req_tready is high only while idle.
// A finished response sits in the output register; while the receiver stalls it
// holds there, and the next request may already be accepted and worked on, only
// its own response waits until the register is free.
// Reset (synchronous, active high) clears the presence flags, the built flag and the
// slot count; the memories need no clearing pass. An encode before any build
// answers "codes not built".
module huffman_code_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cmd[1:0], symbol[6:2], frequency[22:7], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], code_bits[32:2], code_length[37:33], pad
);
   import hcb_pkg::*;

   // request fields
   cmd_type              req_cmd;
   logic [SLOT_BITS-1:0] req_sym;
   logic [15:0]          req_freq;
   logic [FREQ_BITS-1:0] freq_val;
   logic                 req_fire;

   assign req_cmd  = cmd_type'(req_tdata[1:0]);
   assign req_sym  = req_tdata[6:2];
   assign req_freq = req_tdata[22:7];
   assign freq_val = FREQ_BITS'(64'(req_freq) & FREQ_MASK);
   assign req_fire = req_tvalid && req_tready;

   // control and datapath registers
   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    i_ff, i_in;
   logic [CNT_BITS-1:0]    n_ff, n_in;
   logic [SLOT_BITS-1:0]   m_ff, m_in;
   logic [WEIGHT_BITS-1:0] total_ff, total_in;
   logic [SLOT_BITS-1:0]   a_ff, a_in, b_ff, b_in;
   logic [WEIGHT_BITS-1:0] aw_ff, aw_in, bw_ff, bw_in;
   logic [SLOT_BITS-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [ENTRY_BITS-1:0]  base_ff, base_in;
   logic [ADDR_LIMIT-1:0]  nz_ff, nz_in;
   logic                   built_ff, built_in;
   status_type             res_status_ff, res_status_in;
   logic [CODE_BITS-1:0]   res_bits_ff, res_bits_in;
   logic [LEN_BITS-1:0]    res_len_ff, res_len_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [39:0]            rsp_data_ff, rsp_data_in;

   // memory ports
   logic                   freq_we;
   logic [SLOT_BITS-1:0]   freq_waddr, freq_raddr;
   logic [FREQ_BITS-1:0]   freq_rdata;
   logic                   wgt_we;
   logic [SLOT_BITS-1:0]   wgt_waddr, wgt_raddr;
   logic [WEIGHT_BITS-1:0] wgt_wdata, wgt_rdata;
   logic                   map_we;
   logic [SLOT_BITS-1:0]   map_waddr, map_wdata, map_raddr, map_rdata;
   logic                   mrg_we;
   logic [SLOT_BITS-1:0]   mrg_waddr, mrg_raddr;
   logic [2*SLOT_BITS-1:0] mrg_wdata, mrg_rdata;
   logic                   code_we;
   logic [SLOT_BITS-1:0]   code_waddr, code_raddr;
   logic [ENTRY_BITS-1:0]  code_wdata, code_rdata;

   // helpers
   logic                   out_free;
   logic                   pack_hit, pack_last, scan_last, more_merges, replay_last;
   logic [FREQ_BITS-1:0]   pack_freq;
   logic [CNT_BITS-1:0]    n_after;
   logic [WEIGHT_BITS-1:0] total_after, retired;
   logic [SLOT_BITS-1:0]   pair_lo, pair_hi;
   logic                   load_ok;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign pack_hit    = nz_ff[i_ff[SLOT_BITS-1:0]];
   assign pack_freq   = pack_hit ? freq_rdata : '0;
   assign n_after     = n_ff + CNT_BITS'(pack_hit);
   assign total_after = total_ff + WEIGHT_BITS'(pack_freq);
   assign retired     = total_ff + WEIGHT_BITS'(1);
   assign pack_last   = (i_ff == CNT_BITS'(SPAN - 1));
   assign scan_last   = (i_ff == n_ff - CNT_BITS'(1));
   assign more_merges = (CNT_BITS'(m_ff) + CNT_BITS'(2)) < n_ff;
   assign replay_last = (m_ff == SLOT_BITS'(1));
   assign pair_lo     = (a_ff < b_ff) ? a_ff : b_ff;
   assign pair_hi     = (a_ff < b_ff) ? b_ff : a_ff;
   assign load_ok     = (CNT_BITS'(req_sym) < CNT_BITS'(SPAN));

   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_BUILD:  state_in = S_PACK_RD;
                  CMD_ENCODE: state_in = (built_ff && nz_ff[req_sym]) ? S_ENC_MAP : S_OUT;
                  default:    state_in = S_OUT;
               endcase
            end
         end
         S_PACK_RD: state_in = S_PACK_WR;
         S_PACK_WR: begin
            if (pack_last) begin
               state_in = (n_after > CNT_BITS'(1)) ? S_A_RD : S_OUT;
            end else begin
               state_in = S_PACK_RD;
            end
         end
         S_A_RD:  state_in = S_A_CMP;
         S_A_CMP: state_in = scan_last ? S_B_RD : S_A_RD;
         S_B_RD:  state_in = S_B_CMP;
         S_B_CMP: state_in = scan_last ? S_M_LO : S_B_RD;
         S_M_LO:  state_in = S_M_HI;
         S_M_HI:  state_in = more_merges ? S_A_RD : S_R_RD;
         S_R_RD:  state_in = S_R_CODE;
         S_R_CODE: state_in = S_R_HI;
         S_R_HI:  state_in = S_R_LO;
         S_R_LO:  state_in = replay_last ? S_OUT : S_R_RD;
         S_ENC_MAP:  state_in = S_ENC_CODE;
         S_ENC_CODE: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      freq_we    = 1'b0;
      freq_waddr = req_sym;
      freq_raddr = i_ff[SLOT_BITS-1:0];
      wgt_we     = 1'b0;
      wgt_waddr  = n_ff[SLOT_BITS-1:0];
      wgt_wdata  = WEIGHT_BITS'(pack_freq);
      wgt_raddr  = i_ff[SLOT_BITS-1:0];
      map_we     = 1'b0;
      map_waddr  = i_ff[SLOT_BITS-1:0];
      map_wdata  = n_ff[SLOT_BITS-1:0];
      map_raddr  = req_sym;
      mrg_we     = 1'b0;
      mrg_waddr  = m_ff;
      mrg_wdata  = {pair_lo, pair_hi};
      mrg_raddr  = m_ff - SLOT_BITS'(1);
      code_we    = 1'b0;
      code_waddr = n_ff[SLOT_BITS-1:0];
      code_wdata = '0;
      code_raddr = map_rdata;
      case (state_ff)
         S_IDLE: begin
            freq_we = req_fire && (req_cmd == CMD_LOAD) && load_ok;
         end
         S_PACK_WR: begin
            wgt_we  = pack_hit;
            map_we  = pack_hit;
            code_we = pack_hit;
         end
         S_M_LO: begin
            wgt_we    = 1'b1;
            wgt_waddr = pair_lo;
            wgt_wdata = aw_ff + bw_ff;
         end
         S_M_HI: begin
            wgt_we    = 1'b1;
            wgt_waddr = pair_hi;
            wgt_wdata = retired;
            mrg_we    = 1'b1;
         end
         S_R_CODE: begin
            code_raddr = mrg_rdata[2*SLOT_BITS-1:SLOT_BITS];
         end
         S_R_HI: begin
            code_we    = 1'b1;
            code_waddr = hi_ff;
            code_wdata = {code_rdata[ENTRY_BITS-1:CODE_BITS] + LEN_BITS'(1),
                          code_rdata[CODE_BITS-2:0], 1'b1};
         end
         S_R_LO: begin
            code_we    = 1'b1;
            code_waddr = lo_ff;
            code_wdata = {base_ff[ENTRY_BITS-1:CODE_BITS] + LEN_BITS'(1),
                          base_ff[CODE_BITS-2:0], 1'b0};
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      i_in          = i_ff;
      n_in          = n_ff;
      m_in          = m_ff;
      total_in      = total_ff;
      a_in          = a_ff;
      aw_in         = aw_ff;
      b_in          = b_ff;
      bw_in         = bw_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      base_in       = base_ff;
      nz_in         = nz_ff;
      built_in      = built_ff;
      res_status_in = res_status_ff;
      res_bits_in   = res_bits_ff;
      res_len_in    = res_len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_status_in = ST_OK;
               res_bits_in   = '0;
               res_len_in    = '0;
               case (req_cmd)
                  CMD_LOAD: begin
                     if (load_ok) begin
                        nz_in[req_sym] = (freq_val != '0);
                        built_in       = 1'b0;
                     end
                  end
                  CMD_BUILD: begin
                     i_in     = '0;
                     n_in     = '0;
                     m_in     = '0;
                     total_in = '0;
                  end
                  CMD_ENCODE: begin
                     if (!built_ff) begin
                        res_status_in = ST_NOT_BUILT;
                     end else if (!nz_ff[req_sym]) begin
                        res_status_in = ST_ABSENT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PACK_WR: begin
            total_in = total_after;
            n_in     = n_after;
            i_in     = i_ff + CNT_BITS'(1);
            if (pack_last) begin
               i_in  = '0;
               a_in  = '0;
               aw_in = total_after + WEIGHT_BITS'(1);
               if (n_after <= CNT_BITS'(1)) begin
                  built_in = 1'b1;
               end
            end
         end
         S_A_CMP: begin
            if (wgt_rdata <= aw_ff) begin
               a_in  = i_ff[SLOT_BITS-1:0];
               aw_in = wgt_rdata;
            end
            i_in = i_ff + CNT_BITS'(1);
            if (scan_last) begin
               i_in  = '0;
               b_in  = SLOT_BITS'(1);
               bw_in = retired;
            end
         end
         S_B_CMP: begin
            if (i_ff[SLOT_BITS-1:0] != a_ff && wgt_rdata >= aw_ff && wgt_rdata <= bw_ff) begin
               b_in  = i_ff[SLOT_BITS-1:0];
               bw_in = wgt_rdata;
            end
            i_in = i_ff + CNT_BITS'(1);
         end
         S_M_HI: begin
            m_in  = m_ff + SLOT_BITS'(1);
            i_in  = '0;
            a_in  = '0;
            aw_in = retired;
         end
         S_R_CODE: begin
            lo_in = mrg_rdata[2*SLOT_BITS-1:SLOT_BITS];
            hi_in = mrg_rdata[SLOT_BITS-1:0];
         end
         S_R_HI: begin
            base_in = code_rdata;
         end
         S_R_LO: begin
            m_in = m_ff - SLOT_BITS'(1);
            if (replay_last) begin
               built_in = 1'b1;
            end
         end
         S_ENC_CODE: begin
            res_status_in = ST_OK;
            res_bits_in   = code_rdata[CODE_BITS-1:0];
            res_len_in    = code_rdata[ENTRY_BITS-1:CODE_BITS];
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, res_len_in, res_bits_in, res_status_in};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         nz_ff        <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         nz_ff        <= nz_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      m_ff          <= m_in;
      total_ff      <= total_in;
      a_ff          <= a_in;
      aw_ff         <= aw_in;
      b_ff          <= b_in;
      bw_ff         <= bw_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      base_ff       <= base_in;
      res_status_ff <= res_status_in;
      res_bits_ff   <= res_bits_in;
      res_len_ff    <= res_len_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // frequency per symbol
   hcb_ram #(.WIDTH(FREQ_BITS), .DEPTH(ADDR_LIMIT)) u_freq_ram (
      .clock(clock), .wr_en(freq_we), .wr_addr(freq_waddr), .wr_data(freq_val),
      .rd_addr(freq_raddr), .rd_data(freq_rdata));

   // slot weights during merging
   hcb_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ADDR_LIMIT)) u_wgt_ram (
      .clock(clock), .wr_en(wgt_we), .wr_addr(wgt_waddr), .wr_data(wgt_wdata),
      .rd_addr(wgt_raddr), .rd_data(wgt_rdata));

   // symbol to slot
   hcb_ram #(.WIDTH(SLOT_BITS), .DEPTH(ADDR_LIMIT)) u_map_ram (
      .clock(clock), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wdata),
      .rd_addr(map_raddr), .rd_data(map_rdata));

   // merge records {lo, hi}
   hcb_ram #(.WIDTH(2*SLOT_BITS), .DEPTH(ADDR_LIMIT)) u_mrg_ram (
      .clock(clock), .wr_en(mrg_we), .wr_addr(mrg_waddr), .wr_data(mrg_wdata),
      .rd_addr(mrg_raddr), .rd_data(mrg_rdata));

   // code per slot {length, bits}
   hcb_ram #(.WIDTH(ENTRY_BITS), .DEPTH(ADDR_LIMIT)) u_code_ram (
      .clock(clock), .wr_en(code_we), .wr_addr(code_waddr), .wr_data(code_wdata),
      .rd_addr(code_raddr), .rd_data(code_rdata));

   // checks
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("request accepted but controller stayed idle");

   a_not_built_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1:0] == ST_NOT_BUILT |->
         rsp_data_ff[37:2] == '0)
      else $error("not-built response carries a code");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_BITS'(SPAN))
      else $error("slot count beyond table");

endmodule

// ===== sim/tb_huffman_code_builder.sv =====
`timescale 1ns / 100ps

module tb_huffman_code_builder;
   import hcb_pkg::*;

   // one response as the block returns it
   typedef struct {
      logic [1:0]  status;
      logic [30:0] code_bits;
      logic [4:0]  code_length;
   } code_reply_t;

   // directed stimulus row; has_fixed marks rows whose answer is typed in
   typedef struct {
      logic [1:0]  cmd;
      logic [4:0]  sym;
      logic [15:0] freq;
      bit          has_fixed;
      code_reply_t fixed;
   } plan_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // cmd[1:0], symbol[6:2], frequency[22:7], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // status[1:0], code_bits[32:2], code_length[37:33], pad

   huffman_code_builder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // --- shadow of the block state for the code predictor -----------------
   logic [15:0] sh_freq   [SYMBOLS];
   logic [4:0]  sh_sym    [32];
   logic [30:0] sh_code   [32];
   logic [4:0]  sh_len    [32];
   int          sh_slots;
   bit          sh_built;

   code_reply_t pending_codes[$];
   int          mismatches;
   int          unsent_fixed;
   longint      cycle_count;

   // idling knobs; the first two in percent
   int send_gap_pct;
   int recv_stall_pct;
   int hold_off_cycles;   // long receiver hold-off, run by the stall process

   // rebuild the code table from the frequency shadow
   function automatic void rebuild_codes();
      longint unsigned total;
      longint unsigned wt [32];
      int lo_of [32];
      int hi_of [32];
      int n, a, b, lo, hi, m, i;
      longint unsigned aw, bw;
      logic [30:0] base;
      logic [4:0]  blen;
      total = 0;
      n = 0;
      for (i = 0; i < SPAN; i++) begin
         total += sh_freq[i];
         if (sh_freq[i] != 0) begin
            sh_sym[n] = i[4:0];
            wt[n] = sh_freq[i];
            n++;
         end
      end
      sh_slots = n;
      for (m = 0; m + 1 < n; m++) begin
         a = 0;
         b = 1;
         aw = total + 1;
         bw = total + 1;
         // lightest: last slot at the minimum
         for (i = 0; i < n; i++)
            if (wt[i] <= aw) begin
               a = i;
               aw = wt[i];
            end
         // partner: last other slot between the minimum and best so far
         for (i = 0; i < n; i++)
            if (i != a && wt[i] >= aw && wt[i] <= bw) begin
               b = i;
               bw = wt[i];
            end
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         wt[lo] = aw + bw;
         wt[hi] = total + 1;
         lo_of[m] = lo;
         hi_of[m] = hi;
      end
      for (i = 0; i < n; i++) begin
         sh_code[i] = '0;
         sh_len[i] = '0;
      end
      // replay merges backwards: lower slot takes 0, higher slot takes 1
      for (m = (n > 1) ? n - 1 : 0; m > 0; m--) begin
         base = sh_code[lo_of[m-1]];
         blen = sh_len[lo_of[m-1]];
         sh_code[hi_of[m-1]] = {base[29:0], 1'b1};
         sh_len[hi_of[m-1]]  = blen + 5'd1;
         sh_code[lo_of[m-1]] = {base[29:0], 1'b0};
         sh_len[lo_of[m-1]]  = blen + 5'd1;
      end
      sh_built = 1'b1;
   endfunction

   function automatic code_reply_t predict_code(logic [1:0] cmd, logic [4:0] sym,
                                                logic [15:0] freq);
      code_reply_t r;
      r = '{ST_OK, '0, '0};
      if (cmd == CMD_LOAD) begin
         if (sym < SPAN) begin
            sh_freq[sym] = freq;
            sh_built = 1'b0;
         end
      end else if (cmd == CMD_BUILD) begin
         rebuild_codes();
      end else if (cmd == CMD_ENCODE) begin
         if (!sh_built) begin
            r.status = ST_NOT_BUILT;
         end else begin
            r.status = ST_ABSENT;
            for (int i = 0; i < sh_slots; i++)
               if (sh_sym[i] == sym) begin
                  r = '{ST_OK, sh_code[i], sh_len[i]};
                  break;
               end
         end
      end
      return r;
   endfunction

   // offer one request, hold until accepted, queue its expected response;
   // tvalid stays up afterwards and is dropped by the next gap or the drain
   task automatic send_request(logic [1:0] cmd, logic [4:0] sym, logic [15:0] freq,
                               bit has_fixed, code_reply_t fixed);
      code_reply_t guess;
      while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, freq, sym, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      guess = predict_code(cmd, sym, freq);
      if (has_fixed && guess != fixed) unsent_fixed++;  // table row disagrees with predictor
      if (has_fixed) guess = fixed;
      pending_codes = {pending_codes, guess};
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
   endtask

   // --- receiver stall process --------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // --- response checker ----------------------------------------------------
   always @(posedge clock) begin
      code_reply_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tdata[1:0];
         got.code_bits   = rsp_tdata[32:2];
         got.code_length = rsp_tdata[37:33];
         if (pending_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %0d/%h/%0d",
                        got.status, got.code_bits, got.code_length);
         end else begin
            want = pending_codes.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %0d/%h/%0d got %0d/%h/%0d",
                           want.status, want.code_bits, want.code_length,
                           got.status, got.code_bits, got.code_length);
            end
         end
      end
   end

   // --- watchdog --------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3_000_000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // directed table: extremes, every command, and the documented corner cases
   plan_row_t plan[] = '{
      '{CMD_ENCODE, 5'd0,  16'd0,     1, '{ST_NOT_BUILT, 31'd0, 5'd0}},
      '{2'd3,       5'd31, 16'hFFFF,  1, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_BUILD,  5'd0,  16'd0,     1, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_ENCODE, 5'd5,  16'd0,     1, '{ST_ABSENT, 31'd0, 5'd0}},   // nothing present
      '{CMD_LOAD,   5'd31, 16'hFFFF,  1, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_ENCODE, 5'd31, 16'd0,     1, '{ST_NOT_BUILT, 31'd0, 5'd0}},// load drops codes
      '{CMD_BUILD,  5'd0,  16'd0,     1, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_ENCODE, 5'd31, 16'd0,     1, '{ST_OK, 31'd0, 5'd0}},       // single symbol
      '{CMD_ENCODE, 5'd0,  16'd0,     1, '{ST_ABSENT, 31'd0, 5'd0}},
      '{CMD_LOAD,   5'd0,  16'd1,     1, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_LOAD,   5'd7,  16'd1,     1, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_LOAD,   5'd12, 16'd3,     1, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_BUILD,  5'd0,  16'd0,     1, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_ENCODE, 5'd0,  16'd0,     0, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_ENCODE, 5'd7,  16'd0,     0, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_ENCODE, 5'd12, 16'd0,     0, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_ENCODE, 5'd31, 16'd0,     0, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_LOAD,   5'd31, 16'd0,     1, '{ST_OK, 31'd0, 5'd0}},       // zero removes it
      '{CMD_BUILD,  5'd0,  16'd0,     1, '{ST_OK, 31'd0, 5'd0}},
      '{CMD_ENCODE, 5'd31, 16'd0,     1, '{ST_ABSENT, 31'd0, 5'd0}},
      '{CMD_ENCODE, 5'd12, 16'd0,     0, '{ST_OK, 31'd0, 5'd0}}
   };

   // fill every symbol with random weight, build, then encode a batch
   task automatic full_set(int spread, int encodes);
      int i;
      code_reply_t none;
      none = '{ST_OK, '0, '0};
      for (i = 0; i < SYMBOLS; i++)
         send_request(CMD_LOAD, i[4:0],
                      ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(spread, 1)),
                      0, none);
      send_request(CMD_BUILD, 5'($urandom), 16'($urandom), 0, none);
      for (i = 0; i < encodes; i++)
         send_request(CMD_ENCODE, 5'($urandom), 16'($urandom), 0, none);
   endtask

   // random traffic: mostly set-build-encode rounds, some noise
   task automatic random_phase(int rounds);
      code_reply_t none;
      int r, k;
      none = '{ST_OK, '0, '0};
      for (r = 0; r < rounds; r++) begin
         if ($urandom_range(4) == 0) begin
            for (k = 0; k < 6; k++)
               send_request(2'($urandom), 5'($urandom), 16'($urandom), 0, none);
         end else begin
            // a few changed symbols on top of the current table
            for (k = $urandom_range(4, 1); k > 0; k--)
               send_request(CMD_LOAD, 5'($urandom),
                            ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(9)),
                            0, none);
            send_request(CMD_BUILD, 5'($urandom), 16'($urandom), 0, none);
            for (k = 0; k < 6; k++)
               send_request(CMD_ENCODE, 5'($urandom), 16'($urandom), 0, none);
         end
      end
   endtask

   initial begin
      code_reply_t none;
      int i;
      none = '{ST_OK, '0, '0};
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      mismatches = 0;
      unsent_fixed = 0;
      cycle_count = 0;
      send_gap_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      sh_slots = 0;
      sh_built = 1'b0;
      for (i = 0; i < SYMBOLS; i++) sh_freq[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, no idling
      foreach (plan[j])
         send_request(plan[j].cmd, plan[j].sym, plan[j].freq,
                      plan[j].has_fixed, plan[j].fixed);

      // full tables at the frequency extremes
      full_set(1, 8);
      full_set(65535, 8);

      // sender pauses until every response is back
      drain_responses();

      // receiver holds off while requests keep coming
      hold_off_cycles = 400;
      for (i = 0; i < 10; i++)
         send_request(CMD_ENCODE, 5'($urandom), 16'($urandom), 0, none);
      drain_responses();

      send_gap_pct = 45;
      random_phase(15);
      send_gap_pct = 0;
      recv_stall_pct = 45;
      random_phase(15);
      send_gap_pct = 19;
      recv_stall_pct = 19;
      full_set(300, 10);
      random_phase(15);
      send_gap_pct = 0;
      recv_stall_pct = 0;
      random_phase(15);

      drain_responses();
      repeat (200) @(posedge clock);
      mismatches += unsent_fixed;
      if (mismatches == 0 && pending_codes.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
